// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== src/wfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// wfpr_pkg
// Types and constants shared by the wall follower path reducer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wfpr_pkg;

    // Opcodes of an input word.
    localparam logic OP_EXPLORE = 1'b0;
    localparam logic OP_REPLAY  = 1'b1;

    // Turns as clockwise quarter-turn angles.
    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_BACK  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam int LEN_W = 11;

    // Input word.
    typedef struct packed {
        logic opcode;
        logic left_open;
        logic forward_open;
        logic right_open;
        logic back_open;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [1:0]       move;
        logic             moved;
        logic [LEN_W-1:0] path_length;
        logic             path_full;
        logic             path_empty;
    } out_word_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== src/wfpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfpr_ctrl
// Sequencer: takes a word, lets the datapath read the store, then commits
// the update and loads the result register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module wfpr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output wfpr_pkg::dp_cmd_t      cmd
);
    import wfpr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The result register is free when empty or being emptied.
                cmd.commit = !m_valid_reg || m_ready;
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== src/wfpr_datapath.sv =====
// ----------------------------------------------------------------------------
// wfpr_datapath
// Move store, end pointers, move count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wfpr_datapath #(
    parameter int PATH_DEPTH = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wfpr_pkg::dp_cmd_t   cmd,
    input  wire wfpr_pkg::in_word_t  s_word,
    output wfpr_pkg::out_word_t      m_word
);
    import wfpr_pkg::*;

    localparam int PW = $clog2(PATH_DEPTH);
    localparam int CW = $clog2(PATH_DEPTH + 1);

    // Pointer steps with wrap at the store depth.
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(PATH_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(PATH_DEPTH - 1) : p - PW'(1);
    endfunction

    logic [1:0]    mem [PATH_DEPTH];

    logic [PW-1:0] newest_ptr_reg, newest_ptr_next;
    logic [PW-1:0] oldest_ptr_reg, oldest_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    top_reg, top_next;
    in_word_t      item_reg;
    logic [1:0]    rd_data_reg;
    out_word_t     out_reg, out_next;

    logic [PW-1:0] rd_addr;
    logic [PW-1:0] wr_addr;
    logic [1:0]    wr_data;
    logic          wr_en;
    logic [1:0]    choice;
    logic          have;

    // Read address: the entry below the newest for explore, the next
    // oldest for replay.
    assign rd_addr = (s_word.opcode == OP_EXPLORE) ? ptr_inc(newest_ptr_reg)
                                                   : ptr_dec(oldest_ptr_reg);

    // Move store with a registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Left-hand choice: left, forward, right, back.
    always_comb begin
        have   = 1'b1;
        choice = DIR_FWD;
        if (item_reg.left_open) begin
            choice = DIR_LEFT;
        end else if (item_reg.forward_open) begin
            choice = DIR_FWD;
        end else if (item_reg.right_open) begin
            choice = DIR_RIGHT;
        end else if (item_reg.back_open) begin
            choice = DIR_BACK;
        end else begin
            have = 1'b0;
        end
    end

    // Store update and result for the word held in item_reg.
    always_comb begin
        newest_ptr_next = newest_ptr_reg;
        oldest_ptr_next = oldest_ptr_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        wr_addr         = ptr_dec(newest_ptr_reg);
        wr_data         = choice;
        wr_en           = 1'b0;
        out_next        = '0;

        if (item_reg.opcode == OP_EXPLORE) begin
            if (have) begin
                out_next.move  = choice;
                out_next.moved = 1'b1;
                if (count_reg >= CW'(2) && top_reg == DIR_BACK) begin
                    // Back turn on top: fold older, back and new turn into one.
                    wr_addr         = ptr_inc(newest_ptr_reg);
                    wr_data         = rd_data_reg + DIR_BACK + choice;
                    wr_en           = cmd.commit;
                    newest_ptr_next = ptr_inc(newest_ptr_reg);
                    count_next      = count_reg - CW'(1);
                    top_next        = wr_data;
                end else if (count_reg >= CW'(PATH_DEPTH)) begin
                    out_next.path_full = 1'b1;
                end else begin
                    wr_en           = cmd.commit;
                    newest_ptr_next = ptr_dec(newest_ptr_reg);
                    count_next      = count_reg + CW'(1);
                    top_next        = choice;
                end
            end
        end else begin
            if (count_reg == '0) begin
                out_next.path_empty = 1'b1;
            end else begin
                oldest_ptr_next = ptr_dec(oldest_ptr_reg);
                count_next      = count_reg - CW'(1);
                out_next.move   = rd_data_reg;
                out_next.moved  = 1'b1;
            end
        end
        out_next.path_length = LEN_W'(count_next);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_ptr_reg <= '0;
            oldest_ptr_reg <= '0;
            count_reg      <= '0;
        end else if (cmd.commit) begin
            newest_ptr_reg <= newest_ptr_next;
            oldest_ptr_reg <= oldest_ptr_next;
            count_reg      <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_word;
        end
        if (cmd.commit) begin
            top_reg <= top_next;
            out_reg <= out_next;
        end
    end

    assign m_word = out_reg;

endmodule

`default_nettype wire

// ===== src/wall_follower_path_reducer.sv =====
// Left-hand wall follower with online path shortening.
// The s_ channel takes one input word: an opcode and four open-side bits.
// Explore picks left, forward, right, then back, and pushes the turn on the
// newest end of a PATH_DEPTH entry move store; a back turn on top with an
// older move below is folded with them into one turn. Replay pops the
// oldest stored move. The m_ channel returns one result word per input word.
// The result word is registered: the input word and its store read are held
// first, then the update commits and loads the output register.
// A new word is not taken until the previous one has committed, set by the
// move store's single read port: read first, then update and write back.
// A new input word is taken while the previous result still waits in the
// output register; if the receiver stalls, that second word waits in the
// update step until the output register is free, and input stays blocked.
// Reset clears the pointers, the move count, the controller state and the
// result valid flag; the store needs no clearing since only counted entries
// are read.
// ----------------------------------------------------------------------------
// wall_follower_path_reducer
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_follower_path_reducer #(
    parameter int PATH_DEPTH = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire wfpr_pkg::in_word_t  s_word,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output wfpr_pkg::out_word_t      m_word
);
    import wfpr_pkg::*;

    dp_cmd_t cmd;

    // Sequencer.
    wfpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Store and arithmetic.
    wfpr_datapath #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_word  (s_word),
        .m_word  (m_word)
    );

endmodule

`default_nettype wire

// ===== src/wfpr_checker.sv =====
// ----------------------------------------------------------------------------
// wfpr_checker
// Port-level checks on the path reducer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wfpr_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire wfpr_pkg::out_word_t m_word
);
    import wfpr_pkg::*;

    logic idle_move_ok;
    logic empty_ok;

    // A result without a move carries the forward code.
    assign idle_move_ok = m_word.moved || (m_word.move == DIR_FWD);

    // An empty store reports a zero length and no move.
    assign empty_ok = (m_word.path_length == '0) && !m_word.moved && !m_word.path_full;

    // A word in work blocks the input for the following cycle.
    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)

    // Results without a move.
    `ASSERT_CLK(a_idle_move_zero, aclk, aresetn, m_valid |-> idle_move_ok)

    // Replays on an empty store.
    `ASSERT_CLK(a_empty_len, aclk, aresetn, (m_valid && m_word.path_empty) |-> empty_ok)

    // A refused push still reports its chosen turn.
    `ASSERT_CLK(a_full_moved, aclk, aresetn, (m_valid && m_word.path_full) |-> m_word.moved)

    // A stalled result holds.
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_word)))

endmodule

bind wall_follower_path_reducer wfpr_checker u_wfpr_checker (.*);

`default_nettype wire
